>>> rtl/itc_pkg.sv
// Package for the three-counter interval timer: field widths, request and
// mode codes, and the register map of the configuration port.
// No dependencies.
package itc_pkg;

    localparam int NUM_CNT    = 3;
    localparam int RELOAD_W   = 17;
    localparam int COUNT_W    = 18;
    localparam int LATCH_W    = 16;
    localparam int STEP_W     = 8;
    localparam int CALC_W     = 20;

    localparam logic [STEP_W-1:0] TICK_DEC_RESET = 8'd25;
    localparam logic [RELOAD_W-1:0] RELOAD_FULL  = 17'h10000;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -18'sd131072;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req_e;

    // Access field of the control word.
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_MSB   = 2'd1;
    localparam logic [1:0] ACC_LSB   = 2'd2;
    localparam logic [1:0] ACC_WORD  = 2'd3;

    // Count mode codes; of these only one-shot does not count.
    localparam logic [2:0] MODE_TERMINAL = 3'd0;
    localparam logic [2:0] MODE_ONESHOT  = 3'd1;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_SQUARE   = 3'd3;

    localparam logic [1:0] CTRL_PORT = 2'd3;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_TICK_DEC = 3'd0;

endpackage

>>> rtl/interval_timer_three_counter.sv
// Top level of the three-counter interval timer: request register, one pass
// of update logic over the three counters, result register, and APB config.
// Depends on itc_pkg.
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+----------------------------------
//  request   | start in, busy out (always low)   | i_req_type, i_port, i_wdata
//  result    | o_done strobe, one cycle          | o_rdata, o_irq0, o_out_zero/one/two,
//            |                                   | o_speaker_gate, o_speaker_update
//  config    | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A request is registered at the edge that accepts it; the next cycle runs the
// counter update logic, whose result is registered in the result register and
// strobed on o_done. A new request can be taken every cycle.
// Synchronous active-low reset clears all counter state and sets the tick
// decrement to 25. The receiver cannot stall, so busy stays low.
module interval_timer_three_counter
    import itc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_req_type,
    input  logic [1:0]          i_port,
    input  logic [7:0]          i_wdata,
    output logic                o_done,
    output logic [7:0]          o_rdata,
    output logic                o_irq0,
    output logic                o_out_zero,
    output logic                o_out_one,
    output logic                o_out_two,
    output logic                o_speaker_gate,
    output logic                o_speaker_update,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Request register.
    logic                r_valid;
    t_req_e              r_req;
    logic [1:0]          r_port;
    logic [7:0]          r_wdata;

    logic [STEP_W-1:0]   r_tick_dec;

    // Counter state.
    logic [RELOAD_W-1:0]       r_reload [NUM_CNT];
    logic signed [COUNT_W-1:0] r_count  [NUM_CNT];
    logic [LATCH_W-1:0]        r_latch  [NUM_CNT];
    logic [1:0]                r_access [NUM_CNT];
    logic [2:0]                r_cmode  [NUM_CNT];
    logic                      r_bcd    [NUM_CNT];
    logic                      r_toggle [NUM_CNT];
    logic                      r_run    [NUM_CNT];
    logic                      r_out    [NUM_CNT];

    logic [RELOAD_W-1:0]       n_reload [NUM_CNT];
    logic signed [COUNT_W-1:0] n_count  [NUM_CNT];
    logic [LATCH_W-1:0]        n_latch  [NUM_CNT];
    logic [1:0]                n_access [NUM_CNT];
    logic [2:0]                n_cmode  [NUM_CNT];
    logic                      n_bcd    [NUM_CNT];
    logic                      n_toggle [NUM_CNT];
    logic                      n_run    [NUM_CNT];
    logic                      n_out    [NUM_CNT];

    // Result register.
    logic                r_done;
    logic [7:0]          r_rdata;
    logic                r_irq0;
    logic                r_gate;
    logic                r_upd;
    logic [7:0]          n_rdata;
    logic                n_irq0;
    logic                n_gate;
    logic                n_upd;

    logic                cfg_wr;

    function automatic logic signed [COUNT_W-1:0] sat_low(
        input logic signed [CALC_W-1:0] v
    );
        logic signed [CALC_W-1:0] lim;
        lim = CALC_W'(COUNT_MIN);
        return (v < lim) ? COUNT_MIN : v[COUNT_W-1:0];
    endfunction

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[PADDR_W-1:2] == ADDR_TICK_DEC[PADDR_W-1:2])
                  ? {{(32-STEP_W){1'b0}}, r_tick_dec} : 32'd0;

    always_comb begin
        logic [1:0]                sel;
        logic [1:0]                rl;
        logic [2:0]                mode;
        logic                      loaded;
        logic [RELOAD_W-1:0]       wreload;
        logic [STEP_W:0]           step;
        logic signed [CALC_W-1:0]  ext_cnt;
        logic signed [CALC_W-1:0]  diff;
        logic signed [COUNT_W-1:0] after;

        n_reload = r_reload;
        n_count  = r_count;
        n_latch  = r_latch;
        n_access = r_access;
        n_cmode  = r_cmode;
        n_bcd    = r_bcd;
        n_toggle = r_toggle;
        n_run    = r_run;
        n_out    = r_out;
        n_rdata  = 8'd0;
        n_irq0   = 1'b0;
        n_gate   = 1'b0;
        n_upd    = 1'b0;

        sel    = r_wdata[7:6];
        rl     = r_wdata[5:4];
        mode   = r_wdata[3:1];
        // Codes six and seven alias to modes two and three.
        if (mode[1]) begin
            mode[2] = 1'b0;
        end
        loaded  = 1'b0;
        wreload = r_reload[r_port];
        step    = '0;
        ext_cnt = '0;
        diff    = '0;
        after   = '0;

        if (r_valid) begin
            unique case (r_req)
                REQ_WRITE: begin
                    if (r_port != CTRL_PORT) begin
                        case (r_access[r_port])
                            ACC_MSB: begin
                                n_reload[r_port] = {1'b0, r_wdata, 8'd0};
                                n_run[r_port]    = 1'b1;
                                loaded           = 1'b1;
                            end
                            ACC_LSB: begin
                                n_reload[r_port] = {9'd0, r_wdata};
                                n_run[r_port]    = 1'b1;
                                loaded           = 1'b1;
                            end
                            ACC_WORD: begin
                                if (!r_toggle[r_port]) begin
                                    n_reload[r_port] = {1'b0, wreload[15:8], r_wdata};
                                end else begin
                                    n_count[r_port] = {2'b00, r_wdata, wreload[7:0]};
                                    // A zero word loads the full 65536 count.
                                    n_reload[r_port] = ({r_wdata, wreload[7:0]} == 16'd0)
                                                     ? RELOAD_FULL
                                                     : {1'b0, r_wdata, wreload[7:0]};
                                    n_run[r_port] = 1'b1;
                                    loaded        = 1'b1;
                                end
                                n_toggle[r_port] = !r_toggle[r_port];
                            end
                            default: begin
                            end
                        endcase
                        if (loaded) begin
                            if (r_cmode[r_port] <= MODE_ONESHOT) begin
                                n_out[r_port] = 1'b0;
                            end else if (r_cmode[r_port] <= MODE_SQUARE) begin
                                n_out[r_port] = 1'b1;
                            end
                        end
                    end else if (sel != SEL_NONE) begin
                        if (rl == ACC_LATCH) begin
                            n_latch[sel] = r_count[sel][LATCH_W-1:0];
                        end else begin
                            n_access[sel] = rl;
                            n_cmode[sel]  = mode;
                            n_bcd[sel]    = r_wdata[0];
                        end
                        n_toggle[sel] = 1'b0;
                    end
                end
                REQ_READ: begin
                    if (r_port == CTRL_PORT) begin
                        n_rdata = 8'hFF;
                    end else if (r_access[r_port] == ACC_MSB) begin
                        n_rdata = r_latch[r_port][15:8];
                    end else if (r_access[r_port] == ACC_LSB) begin
                        n_rdata = r_latch[r_port][7:0];
                    end else begin
                        n_rdata = r_toggle[r_port] ? r_latch[r_port][15:8]
                                                   : r_latch[r_port][7:0];
                        n_toggle[r_port] = !r_toggle[r_port];
                    end
                end
                REQ_TICK: begin
                    // Outside square-wave mode the speaker gate is forced low.
                    if (r_cmode[2] != MODE_SQUARE) begin
                        n_upd = 1'b1;
                    end
                    for (int i = 0; i < NUM_CNT; i++) begin
                        step    = (r_cmode[i] == MODE_SQUARE) ? {r_tick_dec, 1'b0}
                                                              : {1'b0, r_tick_dec};
                        ext_cnt = CALC_W'(r_count[i]);
                        diff    = ext_cnt - $signed({{(CALC_W-STEP_W-1){1'b0}}, step});
                        after   = sat_low(diff);
                        if (r_run[i]) begin
                            case (r_cmode[i])
                                MODE_TERMINAL: begin
                                    if (after <= 0) begin
                                        n_count[i] = '0;
                                        n_out[i]   = 1'b1;
                                        if (i == 0) begin
                                            n_irq0 = 1'b1;
                                        end
                                    end else begin
                                        n_count[i] = after;
                                    end
                                end
                                MODE_RATE, MODE_SQUARE: begin
                                    if (after <= 0) begin
                                        n_out[i] = !r_out[i];
                                        if (i == 0 && (r_cmode[i] == MODE_RATE || r_out[i])) begin
                                            n_irq0 = 1'b1;
                                        end
                                        if (i == 2 && r_cmode[i] == MODE_SQUARE) begin
                                            n_upd  = 1'b1;
                                            n_gate = (r_reload[i] <
                                                      {{(RELOAD_W-STEP_W-1){1'b0}}, step})
                                                   ? 1'b0 : !r_out[i];
                                        end
                                        n_count[i] = sat_low(CALC_W'(after) +
                                            $signed({{(CALC_W-RELOAD_W){1'b0}}, r_reload[i]}));
                                    end else begin
                                        n_count[i] = after;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_done     <= 1'b0;
            r_tick_dec <= TICK_DEC_RESET;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_reload[i] <= '0;
                r_count[i]  <= '0;
                r_latch[i]  <= '0;
                r_access[i] <= '0;
                r_cmode[i]  <= '0;
                r_bcd[i]    <= 1'b0;
                r_toggle[i] <= 1'b0;
                r_run[i]    <= 1'b0;
                r_out[i]    <= 1'b0;
            end
        end else begin
            r_valid <= start;
            r_done  <= r_valid;
            if (cfg_wr && paddr[PADDR_W-1:2] == ADDR_TICK_DEC[PADDR_W-1:2]) begin
                r_tick_dec <= pwdata[STEP_W-1:0];
            end
            r_reload <= n_reload;
            r_count  <= n_count;
            r_latch  <= n_latch;
            r_access <= n_access;
            r_cmode  <= n_cmode;
            r_bcd    <= n_bcd;
            r_toggle <= n_toggle;
            r_run    <= n_run;
            r_out    <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= t_req_e'(i_req_type);
        r_port  <= i_port;
        r_wdata <= i_wdata;
        r_rdata <= n_rdata;
        r_irq0  <= n_irq0;
        r_gate  <= n_gate;
        r_upd   <= n_upd;
    end

    assign o_done           = r_done;
    assign o_rdata          = r_rdata;
    assign o_irq0           = r_irq0;
    assign o_out_zero       = r_out[0];
    assign o_out_one        = r_out[1];
    assign o_out_two        = r_out[2];
    assign o_speaker_gate   = r_gate;
    assign o_speaker_update = r_upd;

endmodule
